>>> rtl/core/fsi_pkg.sv
package fsi_pkg;

   // field and datapath widths
   localparam int TEMP_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int GRADE_W    = 6;   // memberships in 1/60 units, 0..60
   localparam int TERM_W     = 17;  // one rule's share of the numerator, up to 108000
   localparam int NUM_W      = 20;  // nine terms summed
   localparam int STRENGTH_W = 10;  // nine strengths summed, up to 540
   localparam int DEN_W      = 15;  // 60 times the strength sum
   localparam int SETPOINT_W = 5;

   localparam int NUM_GRADES = 3;
   localparam int NUM_RULES  = NUM_GRADES * NUM_GRADES;

   // the quotient always lands in 16..30 when any rule fires
   localparam int QUOT_MIN   = 16;
   localparam int QUOT_STEPS = 14;  // thresholds 17..30
   localparam int CNT_W      = 4;

   localparam int GRADE_FULL = 60;

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic [COUNT_W-1:0]       count_type;
   typedef logic [GRADE_W-1:0]       grade_type;
   typedef logic [TERM_W-1:0]        term_type;
   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [STRENGTH_W-1:0]    strength_type;
   typedef logic [DEN_W-1:0]         den_type;
   typedef logic [SETPOINT_W-1:0]    setpoint_type;

   // rule index is temp_grade * 3 + occupancy_grade; set bits use Z = 30 - 14a
   // (all warm rules and comfortable-with-many)
   localparam logic [NUM_RULES-1:0] FALLING_RULES = 9'b111_100_000;

   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

   function automatic grade_type grade_cool(input temp_type t);
      grade_type g;
      unique case (t)
         8'sd21:  g = 6'd30;
         8'sd22:  g = 6'd60;
         8'sd23:  g = 6'd30;
         default: g = '0;
      endcase
      return g;
   endfunction

   function automatic grade_type grade_comfy(input temp_type t);
      grade_type g;
      unique case (t)
         8'sd23:  g = 6'd20;
         8'sd24:  g = 6'd40;
         8'sd25:  g = 6'd60;
         8'sd26:  g = 6'd40;
         8'sd27:  g = 6'd20;
         default: g = '0;
      endcase
      return g;
   endfunction

   function automatic grade_type grade_warm(input temp_type t);
      grade_type g;
      unique case (t)
         8'sd27:  g = 6'd60;
         8'sd28:  g = 6'd45;
         8'sd29:  g = 6'd30;
         8'sd30:  g = 6'd15;
         default: g = '0;
      endcase
      return g;
   endfunction

   function automatic grade_type grade_few(input count_type c);
      grade_type g;
      grade_type d;
      d = GRADE_W'(8'd15 - c);
      priority if (c <= 8'd10) begin
         g = 6'd60;
      end else if (c <= 8'd15) begin
         g = GRADE_W'(d * 6'd12);
      end else begin
         g = '0;
      end
      return g;
   endfunction

   function automatic grade_type grade_some(input count_type c);
      grade_type g;
      grade_type up;
      grade_type dn;
      up = GRADE_W'(c - 8'd10);
      dn = GRADE_W'(8'd30 - c);
      priority if (c <= 8'd10) begin
         g = '0;
      end else if (c <= 8'd15) begin
         g = GRADE_W'(up * 6'd12);
      end else if (c <= 8'd20) begin
         g = 6'd60;
      end else if (c <= 8'd30) begin
         g = GRADE_W'(dn * 6'd6);
      end else begin
         g = '0;
      end
      return g;
   endfunction

   function automatic grade_type grade_many(input count_type c);
      grade_type g;
      grade_type up;
      up = GRADE_W'(c - 8'd20);
      priority if (c <= 8'd20) begin
         g = '0;
      end else if (c <= 8'd30) begin
         g = GRADE_W'(up * 6'd6);
      end else begin
         g = 6'd60;
      end
      return g;
   endfunction

endpackage

>>> rtl/core/fsi_if.sv
interface fsi_req_if;
   logic                valid;
   logic                ready;
   fsi_pkg::temp_type   room_temp;
   fsi_pkg::count_type  people_count;

   modport source (output valid, room_temp, people_count, input ready);
   modport sink   (input valid, room_temp, people_count, output ready);
endinterface

interface fsi_rsp_if;
   logic                   valid;
   logic                   ready;
   fsi_pkg::setpoint_type  setpoint;
   logic                   valid_res;

   modport source (output valid, setpoint, valid_res, input ready);
   modport sink   (input valid, setpoint, valid_res, output ready);
endinterface

>>> rtl/core/fuzzy_setpoint_inference_top.sv
// Fuzzy cooling-setpoint inference, Tsukamoto style, exact integer arithmetic.
// Each request transaction carries a signed room temperature and an occupancy
// count; each yields exactly one response transaction with the setpoint
// (16..30 degrees) and valid_res, which is 0 (with setpoint 0) when no rule
// fires, e.g. for any temperature outside 21..30. The block is a six-stage
// pipeline (grading, rule min, rule terms, sums, threshold compares, output
// register) and takes one transaction every cycle while the sink keeps ready
// high. The whole pipe moves on one advance signal, so a stall on the response
// side freezes every stage and ready drops until the output register drains.
// Division by 60*S is done with a bank of fourteen compares, since the
// quotient is known to lie in 16..30.
module fuzzy_setpoint_inference_top (
   input logic        clock,
   input logic        reset,
   fsi_req_if.sink    req_chan,
   fsi_rsp_if.source  rsp_chan
);

   // pipe moves when the output register is empty or being taken
   logic                   advance;
   logic                   out_valid;
   fsi_pkg::stage_ctl_type q_ctl;

   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage 1: temperature and occupancy grades
   fsi_pkg::grade_type tg_in [fsi_pkg::NUM_GRADES];
   fsi_pkg::grade_type og_in [fsi_pkg::NUM_GRADES];
   fsi_pkg::grade_type tg_ff [fsi_pkg::NUM_GRADES];
   fsi_pkg::grade_type og_ff [fsi_pkg::NUM_GRADES];
   logic               v1_ff;

   always_comb begin
      tg_in[0] = fsi_pkg::grade_cool(req_chan.room_temp);
      tg_in[1] = fsi_pkg::grade_comfy(req_chan.room_temp);
      tg_in[2] = fsi_pkg::grade_warm(req_chan.room_temp);
      og_in[0] = fsi_pkg::grade_few(req_chan.people_count);
      og_in[1] = fsi_pkg::grade_some(req_chan.people_count);
      og_in[2] = fsi_pkg::grade_many(req_chan.people_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_chan.valid;
      end
      if (advance) begin
         tg_ff <= tg_in;
         og_ff <= og_in;
      end
   end

   // stage 2: rule strengths, min of each temperature/occupancy pair
   fsi_pkg::grade_type m_in [fsi_pkg::NUM_RULES];
   fsi_pkg::grade_type m_ff [fsi_pkg::NUM_RULES];
   logic               v2_ff;

   always_comb begin
      for (int i = 0; i < fsi_pkg::NUM_GRADES; i++) begin
         for (int j = 0; j < fsi_pkg::NUM_GRADES; j++) begin
            m_in[i*fsi_pkg::NUM_GRADES + j] = (tg_ff[i] < og_ff[j]) ? tg_ff[i] : og_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         m_ff <= m_in;
      end
   end

   // stage 3: per-rule numerator terms (60*Z*a) and strength sum
   //   rising:  960a + 14a^2     falling: 1800a - 14a^2
   fsi_pkg::term_type     term_in [fsi_pkg::NUM_RULES];
   fsi_pkg::term_type     term_ff [fsi_pkg::NUM_RULES];
   fsi_pkg::term_type     sq14 [fsi_pkg::NUM_RULES];
   fsi_pkg::strength_type s_in, s_ff;
   logic                  v3_ff;

   always_comb begin
      s_in = '0;
      for (int r = 0; r < fsi_pkg::NUM_RULES; r++) begin
         sq14[r] = fsi_pkg::TERM_W'(m_ff[r]) * fsi_pkg::TERM_W'(m_ff[r])
                   * fsi_pkg::TERM_W'(14);
         if (fsi_pkg::FALLING_RULES[r]) begin
            term_in[r] = fsi_pkg::TERM_W'(m_ff[r]) * fsi_pkg::TERM_W'(1800) - sq14[r];
         end else begin
            term_in[r] = fsi_pkg::TERM_W'(m_ff[r]) * fsi_pkg::TERM_W'(960) + sq14[r];
         end
         s_in = s_in + fsi_pkg::STRENGTH_W'(m_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         term_ff <= term_in;
         s_ff    <= s_in;
      end
   end

   // stage 4: numerator sum and denominator 60*S
   fsi_pkg::num_type n_in, n_ff;
   fsi_pkg::den_type d_in, d_ff;
   logic             v4_ff;

   always_comb begin
      n_in = '0;
      for (int r = 0; r < fsi_pkg::NUM_RULES; r++) begin
         n_in = n_in + fsi_pkg::NUM_W'(term_ff[r]);
      end
      d_in = fsi_pkg::DEN_W'(s_ff) * fsi_pkg::DEN_W'(fsi_pkg::GRADE_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         n_ff <= n_in;
         d_ff <= d_in;
      end
   end

   // stages 5 and 6: threshold compares, then quotient into the output register
   assign q_ctl.valid   = v4_ff;
   assign q_ctl.advance = advance;

   fsi_quotient u_quotient (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .num       (n_ff),
      .den       (d_ff),
      .setpoint  (rsp_chan.setpoint),
      .valid_res (rsp_chan.valid_res),
      .out_valid (out_valid)
   );

   assign rsp_chan.valid = out_valid;

   // a fired rule set always gives a quotient in 16..30
   a_quot_range : assert property (@(posedge clock) disable iff (reset)
      (v4_ff && d_ff != '0) |->
         (n_ff >= fsi_pkg::NUM_W'(d_ff) * fsi_pkg::NUM_W'(fsi_pkg::QUOT_MIN)) &&
         (n_ff < fsi_pkg::NUM_W'(d_ff) * fsi_pkg::NUM_W'(31)))
      else $error("numerator outside 16..30 times denominator");

   a_valid_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.valid_res) |->
         (rsp_chan.setpoint >= fsi_pkg::SETPOINT_W'(fsi_pkg::QUOT_MIN)) &&
         (rsp_chan.setpoint <= fsi_pkg::SETPOINT_W'(30)))
      else $error("valid setpoint out of range");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.valid_res) |-> rsp_chan.setpoint == '0)
      else $error("invalid result carries nonzero setpoint");

endmodule

>>> rtl/core/fsi_quotient.sv
module fsi_quotient (
   input  logic                   clock,
   input  logic                   reset,
   input  fsi_pkg::stage_ctl_type ctl,
   input  fsi_pkg::num_type       num,
   input  fsi_pkg::den_type       den,
   output fsi_pkg::setpoint_type  setpoint,
   output logic                   valid_res,
   output logic                   out_valid
);

   // compare bank: bit k is set when num >= den * (17 + k)
   logic [fsi_pkg::QUOT_STEPS-1:0] ge_in, ge_ff;
   logic                           nz_in, nz_ff;
   logic                           v5_ff;

   fsi_pkg::setpoint_type sp_in, sp_ff;
   logic                  vr_ff;
   logic                  v6_ff;
   logic [fsi_pkg::CNT_W-1:0] cnt;

   always_comb begin
      for (int k = 0; k < fsi_pkg::QUOT_STEPS; k++) begin
         ge_in[k] = num >= (fsi_pkg::NUM_W'(den)
                            * fsi_pkg::NUM_W'(fsi_pkg::QUOT_MIN + 1 + k));
      end
      nz_in = den != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (ctl.advance) begin
         v5_ff <= ctl.valid;
      end
      if (ctl.advance) begin
         ge_ff <= ge_in;
         nz_ff <= nz_in;
      end
   end

   // thresholds are monotonic, so the count of passed ones is the quotient offset
   always_comb begin
      cnt = '0;
      for (int k = 0; k < fsi_pkg::QUOT_STEPS; k++) begin
         cnt = cnt + fsi_pkg::CNT_W'(ge_ff[k]);
      end
      sp_in = nz_ff ? fsi_pkg::SETPOINT_W'(fsi_pkg::QUOT_MIN)
                      + fsi_pkg::SETPOINT_W'(cnt)
                    : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (ctl.advance) begin
         v6_ff <= v5_ff;
      end
      if (ctl.advance) begin
         sp_ff <= sp_in;
         vr_ff <= nz_ff;
      end
   end

   assign setpoint  = sp_ff;
   assign valid_res = vr_ff;
   assign out_valid = v6_ff;

endmodule
